@@ hdl/lcdseq_pkg.sv @@
// Shared types, op codes and LCD constants for the character-LCD write sequencer.
package lcdseq_pkg;

    // Operation codes carried by an input item
    localparam logic [3:0] OP_TICK      = 4'd0;
    localparam logic [3:0] OP_PUTCHAR   = 4'd1;
    localparam logic [3:0] OP_GOTO      = 4'd2;
    localparam logic [3:0] OP_GOTO_XY   = 4'd3;
    localparam logic [3:0] OP_CLEAR     = 4'd4;
    localparam logic [3:0] OP_CLK_RESET = 4'd5;
    localparam logic [3:0] OP_CLK_STOP  = 4'd6;
    localparam logic [3:0] OP_CLK_START = 4'd7;
    localparam logic [3:0] OP_INIT      = 4'd8;

    // Register select codes
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // LCD bytes
    localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_FUNC_8BIT  = 8'h30;
    localparam logic [7:0] LCD_FUNC_2LINE = 8'h38;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0F;
    localparam logic [7:0] LCD_ENTRY_INC  = 8'h06;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_ONE       = 8'h31;
    localparam logic [7:0] CHAR_TWO       = 8'h32;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_A         = 8'h41;
    localparam logic [7:0] CHAR_F         = 8'h46;
    localparam logic [7:0] CHAR_HEX_BIAS  = 8'h37;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    // DDRAM addresses
    localparam logic [6:0] ADDR_CLOCK = 7'h59;

    // Configuration reset and clock limits
    localparam logic [7:0] TICK_PRESCALE_RESET = 8'd30;
    localparam logic [3:0] DEC_LIMIT = 4'd10;
    localparam logic [2:0] SEX_LIMIT = 3'd6;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Write steps per job (last step index of the longest job)
    localparam logic [3:0] STEP_MAX = 4'd9;

    typedef enum logic [1:0] {
        JOB_SIMPLE = 2'd0,
        JOB_REDRAW = 2'd1,
        JOB_CLEAR  = 2'd2,
        JOB_INIT   = 2'd3
    } job_kind_t;

    // One classified item, ready for expansion into bus writes
    typedef struct packed {
        job_kind_t  kind;
        logic       rs0;
        logic [7:0] byte0;
        logic       jump;
        logic [7:0] jump_byte;
        logic [2:0] min_tens;
        logic [3:0] min_ones;
        logic [2:0] sec_tens;
        logic [3:0] sec_ones;
        logic [3:0] tenths;
        logic [6:0] saved;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       last;
    } bus_write_t;

endpackage

@@ hdl/lcdseq_front.sv @@
// Front end: accepts items, keeps cursor and clock state, classifies items into jobs.
module lcdseq_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [3:0]                op,
    input  logic [7:0]                value,
    input  logic [7:0]                column_char,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [7:0]                tick_prescale,
    output logic                      push,
    output lcdseq_pkg::job_t          push_job,
    input  lcdseq_pkg::queue_status_t q_status
);
    import lcdseq_pkg::*;

    logic [7:0] tick_prescale_reg;
    logic [6:0] cursor_reg, cursor_next;
    logic [7:0] prescale_count_reg, prescale_count_next;
    logic [3:0] tenths_reg, tenths_next;
    logic [3:0] sec_ones_reg, sec_ones_next;
    logic [2:0] sec_tens_reg, sec_tens_next;
    logic [3:0] min_ones_reg, min_ones_next;
    logic [2:0] min_tens_reg, min_tens_next;
    logic       running_reg, running_next;

    logic       accept;
    logic [3:0] adv_tenths, adv_sec_ones, adv_min_ones;
    logic [2:0] adv_sec_tens, adv_min_tens;
    logic [6:0] xy_addr;
    logic [6:0] inc_addr;

    assign in_ready  = !q_status.full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // Advance the mm:ss.t digits by one tenth with carries
    always_comb
    begin
        logic [3:0] t_inc, so_inc, mo_inc;
        logic [2:0] st_inc, mt_inc;
        t_inc  = tenths_reg + 4'd1;
        so_inc = sec_ones_reg + 4'd1;
        st_inc = sec_tens_reg + 3'd1;
        mo_inc = min_ones_reg + 4'd1;
        mt_inc = min_tens_reg + 3'd1;
        adv_tenths   = tenths_reg;
        adv_sec_ones = sec_ones_reg;
        adv_sec_tens = sec_tens_reg;
        adv_min_ones = min_ones_reg;
        adv_min_tens = min_tens_reg;
        if (t_inc < DEC_LIMIT)
        begin
            adv_tenths = t_inc;
        end
        else
        begin
            adv_tenths = 4'd0;
            if (so_inc < DEC_LIMIT)
            begin
                adv_sec_ones = so_inc;
            end
            else
            begin
                adv_sec_ones = 4'd0;
                if (st_inc < SEX_LIMIT)
                begin
                    adv_sec_tens = st_inc;
                end
                else
                begin
                    adv_sec_tens = 3'd0;
                    if (mo_inc < DEC_LIMIT)
                    begin
                        adv_min_ones = mo_inc;
                    end
                    else
                    begin
                        adv_min_ones = 4'd0;
                        adv_min_tens = (mt_inc < SEX_LIMIT) ? mt_inc : 3'd0;
                    end
                end
            end
        end
    end

    // Row and column characters to a DDRAM address
    always_comb
    begin
        logic [6:0] row_base;
        logic [3:0] col_off;
        logic [7:0] hex_diff;
        logic       col_hex, col_dec;
        hex_diff = column_char - CHAR_HEX_BIAS;
        col_hex  = (column_char >= CHAR_A) && (column_char <= CHAR_F);
        col_dec  = (column_char >= CHAR_ZERO) && (column_char <= CHAR_NINE);
        case (value)
            CHAR_ZERO: row_base = 7'h00;
            CHAR_ONE:  row_base = 7'h40;
            CHAR_TWO:  row_base = 7'h10;
            default:   row_base = 7'h50;
        endcase
        if ((value > CHAR_TWO) && col_hex)
            col_off = 4'd8;
        else if (col_hex)
            col_off = hex_diff[3:0];
        else if (col_dec)
            col_off = column_char[3:0];
        else
            col_off = 4'd8;
        xy_addr = row_base | {3'b000, col_off};
    end

    // Two-line address increment
    always_comb
    begin
        if (cursor_reg == 7'h27)
            inc_addr = 7'h40;
        else if (cursor_reg == 7'h67)
            inc_addr = 7'h00;
        else
            inc_addr = cursor_reg + 7'd1;
    end

    // Classify the item and update state
    always_comb
    begin
        cursor_next         = cursor_reg;
        prescale_count_next = prescale_count_reg;
        tenths_next         = tenths_reg;
        sec_ones_next       = sec_ones_reg;
        sec_tens_next       = sec_tens_reg;
        min_ones_next       = min_ones_reg;
        min_tens_next       = min_tens_reg;
        running_next        = running_reg;
        push                = 1'b0;
        push_job            = '0;
        push_job.kind       = JOB_SIMPLE;
        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    if (running_reg)
                    begin
                        if (prescale_count_reg == tick_prescale_reg)
                        begin
                            prescale_count_next = 8'd1;
                            tenths_next   = adv_tenths;
                            sec_ones_next = adv_sec_ones;
                            sec_tens_next = adv_sec_tens;
                            min_ones_next = adv_min_ones;
                            min_tens_next = adv_min_tens;
                        end
                        else
                        begin
                            prescale_count_next = prescale_count_reg + 8'd1;
                        end
                        push          = 1'b1;
                        push_job.kind = JOB_REDRAW;
                    end
                end
                OP_PUTCHAR:
                begin
                    push           = 1'b1;
                    push_job.rs0   = RS_DATA;
                    push_job.byte0 = value;
                    push_job.jump  = 1'b1;
                    case (cursor_reg)
                        7'h0F: cursor_next = 7'h40;
                        7'h4F: cursor_next = 7'h10;
                        7'h1F: cursor_next = 7'h50;
                        7'h58: cursor_next = 7'h00;
                        default:
                        begin
                            cursor_next   = inc_addr;
                            push_job.jump = 1'b0;
                        end
                    endcase
                    push_job.jump_byte = LCD_SET_DDRAM | {1'b0, cursor_next};
                end
                OP_GOTO:
                begin
                    push           = 1'b1;
                    push_job.rs0   = RS_CMD;
                    push_job.byte0 = LCD_SET_DDRAM | value;
                    cursor_next    = value[6:0];
                end
                OP_GOTO_XY:
                begin
                    push           = 1'b1;
                    push_job.rs0   = RS_CMD;
                    push_job.byte0 = LCD_SET_DDRAM | {1'b0, xy_addr};
                    cursor_next    = xy_addr;
                end
                OP_CLEAR:
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_CLEAR;
                    cursor_next   = 7'h00;
                end
                OP_CLK_RESET:
                begin
                    tenths_next   = 4'd0;
                    sec_ones_next = 4'd0;
                    sec_tens_next = 3'd0;
                    min_ones_next = 4'd0;
                    min_tens_next = 3'd0;
                    push          = 1'b1;
                    push_job.kind = JOB_REDRAW;
                end
                OP_CLK_STOP:  running_next = 1'b0;
                OP_CLK_START: running_next = 1'b1;
                OP_INIT:
                begin
                    tenths_next   = 4'd0;
                    sec_ones_next = 4'd0;
                    sec_tens_next = 3'd0;
                    min_ones_next = 4'd0;
                    min_tens_next = 3'd0;
                    cursor_next   = 7'h00;
                    push          = 1'b1;
                    push_job.kind = JOB_INIT;
                end
                default: ;
            endcase
        end
        // Redraws show the updated digits and restore the current cursor
        push_job.min_tens = min_tens_next;
        push_job.min_ones = min_ones_next;
        push_job.sec_tens = sec_tens_next;
        push_job.sec_ones = sec_ones_next;
        push_job.tenths   = tenths_next;
        push_job.saved    = cursor_reg;
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_prescale_reg  <= TICK_PRESCALE_RESET;
            cursor_reg         <= 7'h00;
            prescale_count_reg <= 8'd0;
            tenths_reg         <= 4'd0;
            sec_ones_reg       <= 4'd0;
            sec_tens_reg       <= 3'd0;
            min_ones_reg       <= 4'd0;
            min_tens_reg       <= 3'd0;
            running_reg        <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tick_prescale_reg <= tick_prescale;
            cursor_reg         <= cursor_next;
            prescale_count_reg <= prescale_count_next;
            tenths_reg         <= tenths_next;
            sec_ones_reg       <= sec_ones_next;
            sec_tens_reg       <= sec_tens_next;
            min_ones_reg       <= min_ones_next;
            min_tens_reg       <= min_tens_next;
            running_reg        <= running_next;
        end
    end

endmodule

@@ hdl/lcdseq_queue.sv @@
// Job queue between the front end and the write sequencer.
module lcdseq_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  lcdseq_pkg::job_t          push_job,
    input  logic                      pop,
    output lcdseq_pkg::job_t          head,
    output lcdseq_pkg::queue_status_t status
);
    import lcdseq_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("job popped from an empty queue");

endmodule

@@ hdl/lcdseq_back.sv @@
// Back end: expands queued jobs into bus writes, one per cycle unless stalled, into an output register.
module lcdseq_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lcdseq_pkg::job_t          head,
    input  lcdseq_pkg::queue_status_t q_status,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      reg_select,
    output logic [7:0]                bus_byte,
    output logic                      last_write
);
    import lcdseq_pkg::*;

    logic [3:0] step_reg, step_next;
    logic       out_valid_reg;
    bus_write_t out_reg;
    bus_write_t wr;
    logic       advance;

    // Select the write for the current step of the head job
    always_comb
    begin
        wr = '{rs: RS_CMD, data: LCD_SET_DDRAM, last: 1'b1};
        case (head.kind)
            JOB_SIMPLE:
            begin
                if (step_reg == 4'd0)
                    wr = '{rs: head.rs0, data: head.byte0, last: !head.jump};
                else
                    wr = '{rs: RS_CMD, data: head.jump_byte, last: 1'b1};
            end
            JOB_REDRAW:
            begin
                case (step_reg)
                    4'd0: wr = '{rs: RS_CMD, data: LCD_SET_DDRAM | {1'b0, ADDR_CLOCK},
                                 last: 1'b0};
                    4'd1: wr = '{rs: RS_DATA, data: CHAR_ZERO + {5'b0, head.min_tens},
                                 last: 1'b0};
                    4'd2: wr = '{rs: RS_DATA, data: CHAR_ZERO + {4'b0, head.min_ones},
                                 last: 1'b0};
                    4'd3: wr = '{rs: RS_DATA, data: CHAR_COLON, last: 1'b0};
                    4'd4: wr = '{rs: RS_DATA, data: CHAR_ZERO + {5'b0, head.sec_tens},
                                 last: 1'b0};
                    4'd5: wr = '{rs: RS_DATA, data: CHAR_ZERO + {4'b0, head.sec_ones},
                                 last: 1'b0};
                    4'd6: wr = '{rs: RS_DATA, data: CHAR_DOT, last: 1'b0};
                    4'd7: wr = '{rs: RS_DATA, data: CHAR_ZERO + {4'b0, head.tenths},
                                 last: 1'b0};
                    default: wr = '{rs: RS_CMD, data: LCD_SET_DDRAM | {1'b0, head.saved},
                                    last: 1'b1};
                endcase
            end
            JOB_CLEAR:
            begin
                case (step_reg)
                    4'd0: wr = '{rs: RS_CMD, data: LCD_CLEAR, last: 1'b0};
                    4'd1: wr = '{rs: RS_CMD, data: LCD_SET_DDRAM, last: 1'b0};
                    4'd9: wr = '{rs: RS_CMD, data: LCD_SET_DDRAM, last: 1'b1};
                    default: wr = '{rs: RS_DATA, data: CHAR_SPACE, last: 1'b0};
                endcase
            end
            JOB_INIT:
            begin
                case (step_reg)
                    4'd0, 4'd1, 4'd2: wr = '{rs: RS_CMD, data: LCD_FUNC_8BIT, last: 1'b0};
                    4'd3: wr = '{rs: RS_CMD, data: LCD_FUNC_2LINE, last: 1'b0};
                    4'd4: wr = '{rs: RS_CMD, data: LCD_DISP_ON, last: 1'b0};
                    4'd5: wr = '{rs: RS_CMD, data: LCD_CLEAR, last: 1'b0};
                    default: wr = '{rs: RS_CMD, data: LCD_ENTRY_INC, last: 1'b1};
                endcase
            end
            default: ;
        endcase
    end

    // Load the output register when a job is queued and the register is empty or being drained
    assign advance = !q_status.empty && (!out_valid_reg || out_ready);
    assign pop     = advance && wr.last;

    always_comb
    begin
        step_next = step_reg;
        if (advance)
            step_next = wr.last ? 4'd0 : step_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the write payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= wr;
    end

    assign out_valid  = out_valid_reg;
    assign reg_select = out_reg.rs;
    assign bus_byte   = out_reg.data;
    assign last_write = out_reg.last;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_MAX)
        else $error("write step beyond the longest job");

    a_stall_holds_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(step_reg))
        else $error("write step moved while output stalled");

    a_valid_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(!q_status.empty))
        else $error("write produced without a queued job");

endmodule

@@ hdl/char_lcd_text_and_clock_sequencer_core.sv @@
// Top level: character-LCD text and clock write sequencer.
// An accepted item is written into the job queue, then its first bus write into the output
// register. The back end issues one bus write per cycle unless stalled; an item makes 0 to
// 10 writes (clear 10, redraw 9, init 7, put character 1 or 2, go to 1, stop, start or
// unused 0). The front end takes an item per cycle while the 4-entry job queue has room.
// Reset: asynchronous, active low; cursor, prescale count and digits clear, clock running.
module char_lcd_text_and_clock_sequencer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] op,
    input  logic [7:0] value,
    input  logic [7:0] column_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       reg_select,
    output logic [7:0] bus_byte,
    output logic       last_write,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] tick_prescale
);
    import lcdseq_pkg::*;

    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head;
    queue_status_t q_status;

    lcdseq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .value         (value),
        .column_char   (column_char),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .tick_prescale (tick_prescale),
        .push          (push),
        .push_job      (push_job),
        .q_status      (q_status)
    );

    lcdseq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    lcdseq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reg_select (reg_select),
        .bus_byte   (bus_byte),
        .last_write (last_write)
    );

endmodule

@@ dv/lcdseq_write_checker.sv @@
// Checker: predicts the LCD bus writes of each accepted operation and compares them with the block.
module lcdseq_write_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [3:0] op,
    input  logic [7:0] value,
    input  logic [7:0] column_char,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       reg_select,
    input  logic [7:0] bus_byte,
    input  logic       last_write,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] tick_prescale,
    output int         mismatches,
    output int         writes_due,
    output int         writes_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import lcdseq_pkg::*;

    // Line ends where a character write makes the cursor jump, and the jump targets
    localparam logic [6:0] LINE0_END  = 7'h0F;
    localparam logic [6:0] LINE1_END  = 7'h4F;
    localparam logic [6:0] LINE2_END  = 7'h1F;
    localparam logic [6:0] LINE3_END  = 7'h58;
    localparam logic [7:0] LINE1_HOME = 8'h40;
    localparam logic [7:0] LINE2_HOME = 8'h10;
    localparam logic [7:0] LINE3_HOME = 8'h50;
    localparam logic [7:0] LINE0_HOME = 8'h00;

    // Address counter wrap points in increment mode
    localparam logic [6:0] ROW0_LAST = 7'h27;
    localparam logic [6:0] ROW1_LAST = 7'h67;

    // Base addresses for row/column moves
    localparam logic [6:0] ROW0_BASE = 7'h00;
    localparam logic [6:0] ROW1_BASE = 7'h40;
    localparam logic [6:0] ROW2_BASE = 7'h10;
    localparam logic [6:0] ROW3_BASE = 7'h50;
    localparam logic [6:0] COL_OTHER = 7'd8;

    // Predicted display and clock state
    logic [6:0] cursor;
    logic [7:0] prescale_setting;
    logic [7:0] prescale_cnt;
    logic [3:0] tenths;
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [2:0] min_tens;
    logic       running;

    bus_write_t item_bus_writes[$];
    bus_write_t bus_writes_due[$];

    task automatic emit_write(input logic rs, input logic [7:0] data);
        bus_write_t w;
        w.rs   = rs;
        w.data = data;
        w.last = 1'b0;
        item_bus_writes.push_back(w);
    endtask

    function automatic logic [6:0] next_cursor(input logic [6:0] a);
        if (a == ROW0_LAST) return ROW1_BASE;
        if (a == ROW1_LAST) return ROW0_BASE;
        return a + 7'd1;
    endfunction

    task automatic set_ddram(input logic [7:0] a);
        emit_write(RS_CMD, LCD_SET_DDRAM | a);
        cursor = a[6:0];
    endtask

    // Write one character, then jump to the next display line where the line ends
    task automatic write_char(input logic [7:0] c);
        logic [6:0] was;
        was = cursor;
        emit_write(RS_DATA, c);
        cursor = next_cursor(was);
        case (was)
            LINE0_END: set_ddram(LINE1_HOME);
            LINE1_END: set_ddram(LINE2_HOME);
            LINE2_END: set_ddram(LINE3_HOME);
            LINE3_END: set_ddram(LINE0_HOME);
            default: ;
        endcase
    endtask

    task automatic set_row_col(input logic [7:0] row, input logic [7:0] col);
        logic [6:0] a;
        logic       col_hex;
        logic       col_dec;
        col_hex = (col >= CHAR_A) && (col <= CHAR_F);
        col_dec = (col >= CHAR_ZERO) && (col <= CHAR_NINE);
        case (row)
            CHAR_ZERO: a = ROW0_BASE;
            CHAR_ONE:  a = ROW1_BASE;
            CHAR_TWO:  a = ROW2_BASE;
            default:   a = ROW3_BASE;
        endcase
        // rows past '2' ignore hex columns
        if (row > CHAR_TWO && col_hex) a = a | COL_OTHER;
        else if (col_hex)              a = a | 7'(col - CHAR_HEX_BIAS);
        else if (col_dec)              a = a | 7'(col - CHAR_ZERO);
        else                           a = a | COL_OTHER;
        set_ddram({1'b0, a});
    endtask

    // Draw mm:ss.t at the clock field, then put the cursor back
    task automatic redraw_clock();
        logic [6:0] saved;
        saved = cursor;
        set_ddram({1'b0, ADDR_CLOCK});
        write_char(CHAR_ZERO + 8'(min_tens));
        write_char(CHAR_ZERO + 8'(min_ones));
        write_char(CHAR_COLON);
        write_char(CHAR_ZERO + 8'(sec_tens));
        write_char(CHAR_ZERO + 8'(sec_ones));
        write_char(CHAR_DOT);
        write_char(CHAR_ZERO + 8'(tenths));
        set_ddram({1'b0, saved});
    endtask

    task automatic clear_digits();
        tenths   = '0;
        sec_ones = '0;
        sec_tens = '0;
        min_ones = '0;
        min_tens = '0;
    endtask

    // Ripple the carry through tenths, seconds and minutes
    task automatic advance_tenths();
        tenths = tenths + 4'd1;
        if (tenths < DEC_LIMIT) return;
        tenths   = '0;
        sec_ones = sec_ones + 4'd1;
        if (sec_ones < DEC_LIMIT) return;
        sec_ones = '0;
        sec_tens = sec_tens + 3'd1;
        if (sec_tens < SEX_LIMIT) return;
        sec_tens = '0;
        min_ones = min_ones + 4'd1;
        if (min_ones < DEC_LIMIT) return;
        min_ones = '0;
        min_tens = min_tens + 3'd1;
        if (min_tens < SEX_LIMIT) return;
        min_tens = '0;
    endtask

    task automatic predict_bus_writes(input logic [3:0] code, input logic [7:0] v,
                                      input logic [7:0] c);
        bus_write_t tail;
        item_bus_writes.delete();
        case (code)
            OP_TICK:
            begin
                if (running)
                begin
                    if (prescale_cnt == prescale_setting)
                    begin
                        prescale_cnt = '0;
                        advance_tenths();
                    end
                    prescale_cnt = prescale_cnt + 8'd1;
                    redraw_clock();
                end
            end
            OP_PUTCHAR: write_char(v);
            OP_GOTO:    set_ddram(v);
            OP_GOTO_XY: set_row_col(v, c);
            OP_CLEAR:
            begin
                emit_write(RS_CMD, LCD_CLEAR);
                cursor = '0;
                set_ddram(LINE0_HOME);
                repeat (7) write_char(CHAR_SPACE);
                set_ddram(LINE0_HOME);
            end
            OP_CLK_RESET:
            begin
                clear_digits();
                redraw_clock();
            end
            OP_CLK_STOP:  running = 1'b0;
            OP_CLK_START: running = 1'b1;
            OP_INIT:
            begin
                emit_write(RS_CMD, LCD_FUNC_8BIT);
                emit_write(RS_CMD, LCD_FUNC_8BIT);
                emit_write(RS_CMD, LCD_FUNC_8BIT);
                emit_write(RS_CMD, LCD_FUNC_2LINE);
                emit_write(RS_CMD, LCD_DISP_ON);
                emit_write(RS_CMD, LCD_CLEAR);
                emit_write(RS_CMD, LCD_ENTRY_INC);
                cursor = '0;
                clear_digits();
            end
            default: ;
        endcase
        // flag the final write of the item
        if (item_bus_writes.size() > 0)
        begin
            tail = item_bus_writes.pop_back();
            tail.last = 1'b1;
            item_bus_writes.push_back(tail);
        end
        foreach (item_bus_writes[i]) bus_writes_due.push_back(item_bus_writes[i]);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_write_t want;
        if (!rst_n)
        begin
            cursor           = '0;
            prescale_setting = TICK_PRESCALE_RESET;
            prescale_cnt     = '0;
            clear_digits();
            running          = 1'b1;
            bus_writes_due.delete();
            writes_due       = 0;
        end
        else
        begin
            // compare a write leaving the block with the oldest one due
            if (out_valid && out_ready)
            begin
                writes_checked++;
                if (bus_writes_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: extra write: expected none, actual rs=%0b byte=%02h last=%0b",
                             $time, reg_select, bus_byte, last_write);
                end
                else
                begin
                    want = bus_writes_due.pop_front();
                    compare_field("reg_select", 8'(want.rs), 8'(reg_select));
                    compare_field("bus_byte", want.data, bus_byte);
                    compare_field("last_write", 8'(want.last), 8'(last_write));
                end
            end
            // expand an accepted operation into its writes
            if (in_valid && in_ready) predict_bus_writes(op, value, column_char);
            // capture a prescale register write; it applies from the next operation on
            if (cfg_valid && cfg_ready) prescale_setting = tick_prescale;
            writes_due = bus_writes_due.size();
        end
    end

endmodule

@@ dv/tb_char_lcd_text_and_clock_sequencer_core.sv @@
// Testbench top: drives operations and prescale writes into the LCD sequencer and gives the verdict.
module tb_char_lcd_text_and_clock_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lcdseq_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 80;
    localparam int QUIET_LIMIT   = 1000;
    localparam int CARRY_TICKS   = 14;

    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    // Addresses whose next character write wraps the cursor
    localparam logic [7:0] LINE_ENDS [6] = '{8'h0F, 8'h4F, 8'h1F, 8'h58, 8'h27, 8'h67};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [3:0] op;
    logic [7:0] value;
    logic [7:0] column_char;
    logic       out_valid;
    logic       out_ready;
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last_write;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] tick_prescale;

    int mismatches;
    int writes_due;
    int writes_checked;

    bit         tx_idle;
    bit         rx_idle;
    bit         hold_request;
    int         items_offered;
    int         input_stall_cycles;
    logic [7:0] mid_prescale;

    always #HALF_PERIOD clk = ~clk;

    char_lcd_text_and_clock_sequencer_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .value         (value),
        .column_char   (column_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reg_select    (reg_select),
        .bus_byte      (bus_byte),
        .last_write    (last_write),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .tick_prescale (tick_prescale)
    );

    lcdseq_write_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .value          (value),
        .column_char    (column_char),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reg_select     (reg_select),
        .bus_byte       (bus_byte),
        .last_write     (last_write),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .tick_prescale  (tick_prescale),
        .mismatches     (mismatches),
        .writes_due     (writes_due),
        .writes_checked (writes_checked)
    );

    // Count cycles where the block pushes back on the input
    always @(posedge clk)
    begin
        if (in_valid && !in_ready) input_stall_cycles++;
    end

    // Offer one operation after a random gap and hold it until the transfer
    task automatic offer_item(input logic [3:0] o, input logic [7:0] v, input logic [7:0] c);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        value       <= v;
        column_char <= c;
        do @(posedge clk); while (!in_ready);
        items_offered++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every due write has left and the block has gone quiet
    task automatic drain_block();
        in_valid <= 1'b0;
        while (writes_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_prescale(input logic [7:0] p);
        drain_block();
        cfg_valid     <= 1'b1;
        tick_prescale <= p;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Draw an operation, steering addresses and row/column bytes toward the interesting cases
    task automatic pick_item(output logic [3:0] o, output logic [7:0] v, output logic [7:0] c);
        int r;
        r = $urandom_range(0, 99);
        v = 8'($urandom);
        c = 8'($urandom);
        if (r < 28) o = OP_TICK;
        else if (r < 52) o = OP_PUTCHAR;
        else if (r < 64)
        begin
            o = OP_GOTO;
            if ($urandom_range(0, 1) == 1) v = LINE_ENDS[$urandom_range(0, 5)];
        end
        else if (r < 78)
        begin
            o = OP_GOTO_XY;
            case ($urandom_range(0, 4))
                0: v = CHAR_ZERO;
                1: v = CHAR_ONE;
                2: v = CHAR_TWO;
                3: v = CHAR_TWO + 8'd1;
                default: ;
            endcase
            case ($urandom_range(0, 2))
                0: c = CHAR_A + 8'($urandom_range(0, 5));
                1: c = CHAR_ZERO + 8'($urandom_range(0, 9));
                default: ;
            endcase
        end
        else if (r < 82) o = OP_CLEAR;
        else if (r < 86) o = OP_CLK_RESET;
        else if (r < 89) o = OP_CLK_STOP;
        else if (r < 94) o = OP_CLK_START;
        else if (r < 96) o = OP_INIT;
        else o = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endtask

    // Run random operations until n of them are ones the block acts on
    task automatic run_random(input int n);
        logic [3:0] o;
        logic [7:0] v;
        logic [7:0] c;
        int         done;
        done = 0;
        while (done < n)
        begin
            pick_item(o, v, c);
            offer_item(o, v, c);
            if (o <= OP_INIT) done++;
        end
    endtask

    // Receiver: random stalls per write, plus one long hold-off on request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_TICK;
        value         = '0;
        column_char   = '0;
        cfg_valid     = 1'b0;
        tick_prescale = TICK_PRESCALE_RESET;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        hold_request  = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fastest prescale from a fresh count: after the first tick every tick
        // advances a tenth, so the digits carry into the seconds
        set_prescale(8'd1);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (CARRY_TICKS) offer_item(OP_TICK, 8'($urandom), 8'($urandom));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_prescale(TICK_PRESCALE_RESET);

        // Directed pass at the reset prescale
        offer_item(OP_INIT, 8'h00, 8'h00);
        offer_item(OP_CLEAR, 8'hFF, 8'hFF);
        offer_item(OP_PUTCHAR, 8'h00, 8'h00);
        offer_item(OP_PUTCHAR, 8'hFF, 8'hFF);
        // each line end, then a character to force the wrap
        foreach (LINE_ENDS[i])
        begin
            offer_item(OP_GOTO, LINE_ENDS[i], 8'h00);
            offer_item(OP_PUTCHAR, 8'($urandom), 8'($urandom));
        end
        offer_item(OP_GOTO, 8'hFF, 8'hFF);
        offer_item(OP_GOTO_XY, CHAR_ZERO, CHAR_NINE);
        offer_item(OP_GOTO_XY, CHAR_ONE, CHAR_A);
        offer_item(OP_GOTO_XY, CHAR_TWO, CHAR_F);
        offer_item(OP_GOTO_XY, CHAR_TWO + 8'd1, CHAR_A + 8'd2);
        offer_item(OP_GOTO_XY, 8'hFF, 8'h00);
        offer_item(OP_TICK, 8'h00, 8'h00);
        // stopped clock: ticks do nothing, a clock reset still redraws
        offer_item(OP_CLK_STOP, 8'h00, 8'h00);
        offer_item(OP_TICK, 8'h00, 8'h00);
        offer_item(OP_CLK_RESET, 8'h00, 8'h00);
        offer_item(OP_CLK_START, 8'h00, 8'h00);
        offer_item(OP_TICK, 8'h00, 8'h00);
        offer_item(OP_UNUSED_LO, 8'hFF, 8'hFF);
        offer_item(OP_UNUSED_HI, 8'h00, 8'h00);

        // Fastest prescale, random traffic, then a stretch without idling
        set_prescale(8'd1);
        run_random(20);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_random(10);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // Slowest prescale: hold off the output while ticks pile up on the input
        set_prescale(8'hFF);
        offer_item(OP_CLK_START, 8'h00, 8'h00);
        tx_idle      = 1'b0;
        hold_request = 1'b1;
        repeat (12) offer_item(OP_TICK, 8'($urandom), 8'($urandom));
        tx_idle = 1'b1;
        run_random(10);

        mid_prescale = 8'($urandom_range(2, 254));
        set_prescale(mid_prescale);
        run_random(8);
        drain_block();

        $display("Run covered %0d operations and %0d bus writes at prescale 1, 30, 255 and %0d,",
                 items_offered, writes_checked, mid_prescale);
        $display("with %0d input stall cycles under output hold-off and a tenths carry into seconds.",
                 input_stall_cycles);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
